// File: hdl/rolling_xor_frame_deframer_top_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef ROLLING_XOR_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define ROLLING_XOR_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Once the antecedent holds, the consequent must hold in the same cycle.
`define RXFD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rxfd: implication check failed");

// A stalled item keeps the signal stable into the next cycle.
`define RXFD_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rstn) ((vld) && !(rdy)) |=> \
        $stable(sig)) else $error("rxfd: stalled item changed");

`endif

// File: hdl/rxfd_pkg.sv
package rxfd_pkg;

    typedef enum logic [2:0] {
        ST_PAYLOAD    = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_ZERO_KEY   = 3'd2,
        ST_BAD_MARKER = 3'd3,
        ST_BAD_TYPE   = 3'd4,
        ST_BAD_LENGTH = 3'd5
    } status_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MARKER_KEY = 2'd0;
    localparam logic [1:0] CFG_CODE_MASK  = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

    // Frame layout, as byte offsets within a frame.
    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam logic [31:0] POS_MARKER = 32'd1;
    localparam logic [31:0] POS_TYPE   = 32'd2;
    localparam logic [31:0] POS_FLAGS  = 32'd3;
    localparam logic [31:0] POS_LENGTH = 32'd4;
    localparam logic [31:0] POS_OPCODE = POS_LENGTH + WORD_BYTES;
    localparam logic [31:0] HDR_PLAIN  = POS_OPCODE + WORD_BYTES;
    localparam logic [31:0] HDR_PACKED = HDR_PLAIN + WORD_BYTES;

    typedef struct packed {
        logic [7:0]  marker_key;
        logic [7:0]  code_mask;
        logic [31:0] max_length;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte;
        logic        last;
        logic        compressed;
        logic [31:0] op_code;
        logic [31:0] frame_size;
        logic [31:0] unpacked_size;
    } result_t;

endpackage

// File: hdl/rxfd_in_reg.sv
module rxfd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_in_byte,
    input  logic       advance,
    output logic       item_valid,
    output logic       item_action,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic       action_reg;
    logic [7:0] byte_reg;

    // The slot frees up in the same cycle that its item moves on.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            byte_reg   <= s_in_byte;
        end
    end

    assign item_valid  = valid_reg;
    assign item_action = action_reg;
    assign item_byte   = byte_reg;

endmodule

// File: hdl/rxfd_core.sv
module rxfd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             item_action,
    input  logic [7:0]       item_byte,
    input  rxfd_pkg::cfg_t   cfg,
    output logic             res_valid,
    output rxfd_pkg::result_t res
);

    import rxfd_pkg::*;

    logic [31:0] pos_reg, pos_next;
    logic [7:0]  key_reg, key_next;
    logic        disc_reg, disc_next;
    logic        comp_reg, comp_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] op_reg, op_next;
    logic [31:0] orig_reg, orig_next;

    logic [7:0]  plain;
    logic [31:0] hdr;
    logic [31:0] placed;
    status_t     res_status;
    logic [7:0]  res_data;
    logic        res_last;

    assign plain  = item_byte ^ key_reg;
    assign hdr    = comp_reg ? HDR_PACKED : HDR_PLAIN;
    // Little-endian word fields: the low two offset bits pick the byte lane.
    assign placed = {24'd0, plain} << {pos_reg[1:0], 3'b000};

    always_comb begin
        pos_next   = pos_reg;
        key_next   = key_reg;
        disc_next  = disc_reg;
        comp_next  = comp_reg;
        len_next   = len_reg;
        op_next    = op_reg;
        orig_next  = orig_reg;
        res_valid  = 1'b0;
        res_status = ST_PAYLOAD;
        res_data   = 8'd0;
        res_last   = 1'b0;

        if (item_action) begin
            pos_next  = 32'd0;
            key_next  = 8'd0;
            disc_next = 1'b0;
            comp_next = 1'b0;
            len_next  = 32'd0;
            op_next   = 32'd0;
            orig_next = 32'd0;
        end else if (!disc_reg) begin
            if (pos_reg == 32'd0) begin
                comp_next = 1'b0;
                len_next  = 32'd0;
                op_next   = 32'd0;
                orig_next = 32'd0;
                key_next  = item_byte ^ cfg.marker_key;
                if (key_next == 8'd0) begin
                    disc_next  = 1'b1;
                    res_valid  = 1'b1;
                    res_status = ST_ZERO_KEY;
                end else begin
                    pos_next = POS_MARKER;
                end
            end else begin
                key_next = key_reg + 8'd1;
                pos_next = pos_reg + 32'd1;
                if (pos_reg == POS_MARKER) begin
                    if (plain != cfg.marker_key) begin
                        disc_next  = 1'b1;
                        res_valid  = 1'b1;
                        res_status = ST_BAD_MARKER;
                    end
                end else if (pos_reg == POS_TYPE) begin
                    if ((plain & cfg.code_mask) == 8'd0) begin
                        disc_next  = 1'b1;
                        res_valid  = 1'b1;
                        res_status = ST_BAD_TYPE;
                    end
                end else if (pos_reg == POS_FLAGS) begin
                    comp_next = (plain != 8'd0);
                end else if (pos_reg < POS_OPCODE) begin
                    len_next = len_reg | placed;
                    if (pos_reg == POS_OPCODE - 32'd1 &&
                        (len_next < hdr || len_next > cfg.max_length)) begin
                        disc_next  = 1'b1;
                        res_valid  = 1'b1;
                        res_status = ST_BAD_LENGTH;
                    end
                end else if (pos_reg < HDR_PLAIN) begin
                    op_next = op_reg | placed;
                    if (pos_reg == HDR_PLAIN - 32'd1 && !comp_reg &&
                        len_reg == HDR_PLAIN) begin
                        pos_next   = 32'd0;
                        res_valid  = 1'b1;
                        res_status = ST_EMPTY;
                        res_last   = 1'b1;
                    end
                end else if (comp_reg && pos_reg < HDR_PACKED) begin
                    orig_next = orig_reg | placed;
                    if (pos_reg == HDR_PACKED - 32'd1 && len_reg == HDR_PACKED) begin
                        pos_next   = 32'd0;
                        res_valid  = 1'b1;
                        res_status = ST_EMPTY;
                        res_last   = 1'b1;
                    end
                end else begin
                    res_valid  = 1'b1;
                    res_status = ST_PAYLOAD;
                    res_data   = plain;
                    res_last   = (pos_reg == len_reg - 32'd1);
                    if (res_last) begin
                        pos_next = 32'd0;
                    end
                end
            end
        end
    end

    // Header fields reported with a result are those after this byte.
    assign res.status        = res_status;
    assign res.data_byte     = res_data;
    assign res.last          = res_last;
    assign res.compressed    = comp_next;
    assign res.op_code       = op_next;
    assign res.frame_size    = len_next;
    assign res.unpacked_size = orig_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 32'd0;
            key_reg  <= 8'd0;
            disc_reg <= 1'b0;
            comp_reg <= 1'b0;
            len_reg  <= 32'd0;
            op_reg   <= 32'd0;
            orig_reg <= 32'd0;
        end else if (advance) begin
            pos_reg  <= pos_next;
            key_reg  <= key_next;
            disc_reg <= disc_next;
            comp_reg <= comp_next;
            len_reg  <= len_next;
            op_reg   <= op_next;
            orig_reg <= orig_next;
        end
    end

endmodule

// File: hdl/rxfd_out_reg.sv
module rxfd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rxfd_pkg::result_t res,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output rxfd_pkg::result_t m_res
);

    import rxfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// File: hdl/rolling_xor_frame_deframer_top.sv
// Rolling-XOR frame deframer. Each input item is either one encrypted stream
// byte or an abort; an item yields at most one result item, which is a
// decrypted payload byte, an empty-frame notice or an error report, each
// carrying the header fields seen so far. The block takes one item per clock
// cycle while the result stream is not stalled. An item waits in the input
// register, and when it moves on its result is loaded into the result
// register, from which it is offered on the result stream.
// All decoding for an item (key XOR, key increment, offset compare and
// header field capture) sits in the single logic stage between those two
// registers. When the result register is full and not being drained, the
// input register holds its item and s_ready drops; s_ready depends
// combinationally on m_ready. After an error the block reports nothing until
// an abort item arrives. Configuration writes are always taken, and should
// only be issued while the block is idle.
module rolling_xor_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_in_byte,
    // Result stream.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_data_byte,
    output logic        m_last,
    output logic        m_compressed,
    output logic [31:0] m_op_code,
    output logic [31:0] m_frame_size,
    output logic [31:0] m_unpacked_size,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import rxfd_pkg::*;

    logic       item_valid;
    logic       item_action;
    logic [7:0] item_byte;
    logic       advance;
    logic       can_load;
    logic       res_valid;
    result_t    res;
    result_t    m_res;
    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    // Configuration registers. An index with no register behind it is
    // accepted and dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MARKER_KEY: cfg_next.marker_key = cfg_data[7:0];
                CFG_CODE_MASK:  cfg_next.code_mask  = cfg_data[7:0];
                CFG_MAX_LENGTH: cfg_next.max_length = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.marker_key <= 8'd0;
            cfg_reg.code_mask  <= 8'd1;
            cfg_reg.max_length <= 32'd50000000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // An item is decoded when the result register has room for whatever it
    // may produce; items that produce nothing still wait for that room.
    assign advance = item_valid && can_load;

    rxfd_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_in_byte   (s_in_byte),
        .advance     (advance),
        .item_valid  (item_valid),
        .item_action (item_action),
        .item_byte   (item_byte)
    );

    rxfd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item_action (item_action),
        .item_byte   (item_byte),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    rxfd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_status        = m_res.status;
    assign m_data_byte     = m_res.data_byte;
    assign m_last          = m_res.last;
    assign m_compressed    = m_res.compressed;
    assign m_op_code       = m_res.op_code;
    assign m_frame_size    = m_res.frame_size;
    assign m_unpacked_size = m_res.unpacked_size;

endmodule

// File: hdl/rxfd_checker.sv
`include "rolling_xor_frame_deframer_top_defines.svh"

module rxfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_data_byte,
    input logic        m_last,
    input logic [31:0] m_frame_size
);

    import rxfd_pkg::*;

    logic side_shown;
    logic fault_shown;
    logic empty_shown;
    logic hdr_sized;

    // Results other than payload bytes, errors alone, and empty-frame notices.
    assign side_shown  = m_valid && m_status != ST_PAYLOAD;
    assign fault_shown = side_shown && m_status != ST_EMPTY;
    assign empty_shown = m_valid && m_status == ST_EMPTY;
    assign hdr_sized   = m_frame_size == HDR_PLAIN || m_frame_size == HDR_PACKED;

    `RXFD_ASSERT_HOLD(a_valid_hold, aclk, aresetn, m_valid, m_ready, m_valid)
    `RXFD_ASSERT_HOLD(a_data_hold, aclk, aresetn, m_valid, m_ready, m_data_byte)
    `RXFD_ASSERT_IMPL(a_no_data_off_payload, aclk, aresetn, side_shown, m_data_byte == 8'd0)
    `RXFD_ASSERT_IMPL(a_error_not_last, aclk, aresetn, fault_shown, !m_last)
    `RXFD_ASSERT_IMPL(a_empty_is_header, aclk, aresetn, empty_shown, m_last && hdr_sized)

endmodule

bind rolling_xor_frame_deframer_top rxfd_checker u_rxfd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_data_byte  (m_data_byte),
    .m_last       (m_last),
    .m_frame_size (m_frame_size)
);
